@@ rtl/unique_key_list_table_macros.svh @@
`ifndef UNIQUE_KEY_LIST_TABLE_MACROS_SVH
`define UNIQUE_KEY_LIST_TABLE_MACROS_SVH

// same-cycle implication, checked while out of reset
`define UKL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ukl assertion failed");

// next-cycle implication, checked while out of reset
`define UKL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ukl assertion failed");

`endif

@@ rtl/ukl_pkg.sv @@
package ukl_pkg;

  localparam int CAPACITY     = 64;
  localparam int PAYLOAD_BITS = 64;

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int KEY_W  = 32;
  localparam int WORD_W = KEY_W + PAYLOAD_BITS;

  // stream field widths
  localparam int MODE_W    = 2;
  localparam int PAY_IN_W  = 64;
  localparam int POS_W     = 6;
  localparam int PROBE_W   = 7;
  localparam int ENTRY_W   = 7;
  localparam int S_DATA_W  = 104;
  localparam int M_DATA_W  = 120;

  typedef enum logic [MODE_W-1:0] {
    MODE_FIND   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_READ   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SHIFT,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                    ok;
    logic [IDX_W-1:0]        fpos;
    logic [CNT_W-1:0]        probes;
    logic [KEY_W-1:0]        rkey;
    logic [PAYLOAD_BITS-1:0] rpay;
  } res_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
  } ram_req_t;

endpackage

@@ rtl/ukl_ram.sv @@
module ukl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                             wr_data_i,
  input  logic                                         rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                             rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/ukl_ctrl.sv @@
module ukl_ctrl
  import ukl_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [MODE_W-1:0]       mode_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  input  logic [POS_W-1:0]        position_i,
  output ram_req_t                ram_req_o,
  input  logic [WORD_W-1:0]       ram_rdata_i,
  output logic                    res_valid_o,
  input  logic                    res_take_i,
  output res_t                    res_o,
  output logic [CNT_W-1:0]        count_o
);

  state_e                  state_q, state_d;
  mode_e                   mode_q;
  logic [KEY_W-1:0]        key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [POS_W-1:0]        pos_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        ptr_q, ptr_d;
  logic                    vld_q, vld_d;
  res_t                    res_q, res_d;

  logic             hit;
  logic [IDX_W-1:0] prev_idx;

  assign hit      = vld_q && (ram_rdata_i[KEY_W-1:0] == key_q);
  assign prev_idx = IDX_W'(ptr_q - CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_e'(mode_i);
      key_q  <= key_i;
      pay_q  <= payload_i;
      pos_q  <= position_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    vld_d       = vld_q;
    res_d       = res_q;
    ram_req_o   = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end

      ST_DECODE: begin
        res_d = '0;
        if (mode_q == MODE_READ) begin
          if (CNT_W'(pos_q) < count_q) begin
            ram_req_o.rd_en   = 1'b1;
            ram_req_o.rd_addr = IDX_W'(pos_q);
            state_d           = ST_READ;
          end else begin
            state_d = ST_DONE;
          end
        end else if (mode_q == MODE_ADD && count_q == CNT_W'(CAPACITY)) begin
          state_d = ST_DONE;
        end else begin
          // start the scan at entry 0, compares lag reads by the memory's read register
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = '0;
          ptr_d             = CNT_W'(1);
          vld_d             = (count_q != '0);
          state_d           = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (hit) begin
          res_d.probes = ptr_q;
          case (mode_q)
            MODE_FIND: begin
              res_d.ok   = 1'b1;
              res_d.fpos = prev_idx;
              state_d    = ST_DONE;
            end
            MODE_REMOVE: begin
              res_d.ok   = 1'b1;
              res_d.fpos = prev_idx;
              if (ptr_q < count_q) begin
                ram_req_o.rd_en   = 1'b1;
                ram_req_o.rd_addr = IDX_W'(ptr_q);
                state_d           = ST_SHIFT;
              end else begin
                count_d = count_q - CNT_W'(1);
                state_d = ST_DONE;
              end
            end
            default: begin
              // duplicate key on add
              state_d = ST_DONE;
            end
          endcase
        end else if (!vld_q || ptr_q == count_q) begin
          res_d.probes = count_q;
          if (mode_q == MODE_ADD) begin
            ram_req_o.wr_en   = 1'b1;
            ram_req_o.wr_addr = IDX_W'(count_q);
            ram_req_o.wr_data = {pay_q, key_q};
            res_d.ok          = 1'b1;
            res_d.fpos        = IDX_W'(count_q);
            count_d           = count_q + CNT_W'(1);
          end
          state_d = ST_DONE;
        end else begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = IDX_W'(ptr_q);
          ptr_d             = ptr_q + CNT_W'(1);
        end
      end

      ST_SHIFT: begin
        // move entry ptr down one place while the next one is fetched
        ram_req_o.wr_en   = 1'b1;
        ram_req_o.wr_addr = prev_idx;
        ram_req_o.wr_data = ram_rdata_i;
        if (ptr_q + CNT_W'(1) == count_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = ST_DONE;
        end else begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = IDX_W'(ptr_q + CNT_W'(1));
          ptr_d             = ptr_q + CNT_W'(1);
        end
      end

      ST_READ: begin
        res_d.ok   = 1'b1;
        res_d.fpos = IDX_W'(pos_q);
        res_d.rkey = ram_rdata_i[KEY_W-1:0];
        res_d.rpay = ram_rdata_i[WORD_W-1:KEY_W];
        state_d    = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o   = res_q;
  assign count_o = count_q;

endmodule

@@ rtl/unique_key_list_table.sv @@
// Packed, unsorted list of up to 64 entries, each a unique signed 32-bit key
// with a 64-bit payload, kept in one single-port-read memory. tuser selects the
// operation (find, add, remove, read by position). Every accepted item gives
// exactly one result. Find, add and remove scan the list one key compare per
// cycle on the memory read port; a remove stops its scan at the match and then
// moves each later entry down one place, one entry per cycle, so scan and
// shift together visit each of the n entries once. Add on a full list and a
// read out of range finish without reading the memory. One item is in work at
// a time; a finished result sits in the output register, so the next item is
// taken while it waits. The memory is not cleared at reset: only entries below
// the entry count are ever used.
module unique_key_list_table
  import ukl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // key[31:0], payload[95:32], position[101:96], zero fill
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]   s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // ok[0], found_position[6:1], probe_count[13:7], record_key[45:14],
  // record_payload[109:46], entries_now[116:110], zero fill
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  ram_req_t          ram_req;
  logic [WORD_W-1:0] ram_rdata;
  res_t              res;
  logic              res_valid;
  logic              res_take;
  logic [CNT_W-1:0]  count;

  logic                m_valid_q;
  logic [M_DATA_W-1:0] m_data_q;

  ukl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .key_i       (s_axis_tdata[31:0]),
    .payload_i   (PAYLOAD_BITS'(s_axis_tdata[95:32])),
    .position_i  (s_axis_tdata[101:96]),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res),
    .count_o     (count)
  );

  ukl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_req.wr_en),
    .wr_addr_i (ram_req.wr_addr),
    .wr_data_i (ram_req.wr_data),
    .rd_en_i   (ram_req.rd_en),
    .rd_addr_i (ram_req.rd_addr),
    .rd_data_o (ram_rdata)
  );

  // result moves into the output register when it is empty or draining
  assign res_take = res_valid && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_take) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      m_data_q <= {3'b000,
                   ENTRY_W'(count),
                   PAY_IN_W'(res.rpay),
                   res.rkey,
                   PROBE_W'(res.probes),
                   POS_W'(res.fpos),
                   res.ok};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

@@ rtl/ukl_chk.sv @@
`include "unique_key_list_table_macros.svh"

module ukl_chk
  import ukl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [S_DATA_W-1:0] s_axis_tdata,
  input logic [MODE_W-1:0]   s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [M_DATA_W-1:0] m_axis_tdata
);

  logic                   out_ok;
  logic [PROBE_W-1:0]     out_probes;
  logic [ENTRY_W-1:0]     out_entries;
  logic                   in_xfer;

  assign out_ok      = m_axis_tdata[0];
  assign out_probes  = m_axis_tdata[13:7];
  assign out_entries = m_axis_tdata[116:110];
  assign in_xfer     = s_axis_tvalid && s_axis_tready && (s_axis_tuser != '1 || s_axis_tdata[0]
                       || !s_axis_tdata[0]);

  // list never grows past its capacity
  `UKL_ASSERT_IMPL(a_entries_cap, clk_i, rst_ni, m_axis_tvalid,
                   out_entries <= ENTRY_W'(CAPACITY))

  // a failed operation reports zero position and zero record
  `UKL_ASSERT_IMPL(a_fail_zero, clk_i, rst_ni, m_axis_tvalid && !out_ok,
                   m_axis_tdata[6:1] == '0 && m_axis_tdata[109:14] == '0)

  // the scan never compares more keys than the list held before the operation
  `UKL_ASSERT_IMPL(a_probe_bound, clk_i, rst_ni, m_axis_tvalid,
                   out_probes <= out_entries + PROBE_W'(1))

  // a new item is not taken in the cycle right after one was taken
  `UKL_ASSERT_NEXT(a_one_in_work, clk_i, rst_ni, in_xfer, !s_axis_tready)

  // stalled result holds
  `UKL_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind unique_key_list_table ukl_chk u_ukl_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ verif/tb.sv @@
module tb;
  import ukl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int S_FILL_W = S_DATA_W - POS_W - PAY_IN_W - KEY_W;

  typedef struct packed {
    logic                    ok;
    logic [POS_W-1:0]        at;
    logic [PROBE_W-1:0]      probes;
    logic [KEY_W-1:0]        rkey;
    logic [PAYLOAD_BITS-1:0] rpay;
    logic [ENTRY_W-1:0]      entries;
  } list_outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [MODE_W-1:0]   s_axis_tuser = MODE_FIND;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  // shadow copy of the list contents
  logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
  logic [PAYLOAD_BITS-1:0] shadow_pays [CAPACITY];
  int unsigned             shadow_count = 0;

  list_outcome_t due_results [$];
  int unsigned   mismatches = 0;
  bit            steady = 1'b0;

  unique_key_list_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 27);
  end

  function automatic void scan_keys(input logic signed [KEY_W-1:0] k, output bit hit,
                                    output int unsigned at, output int unsigned probes);
    int unsigned i;
    hit = 1'b0;
    at = 0;
    probes = 0;
    for (i = 0; i < shadow_count; i++) begin
      probes++;
      if (shadow_keys[i] == k) begin
        hit = 1'b1;
        at = i;
        return;
      end
    end
  endfunction

  // applies one operation to the shadow list and returns the result it gives
  function automatic list_outcome_t list_op_outcome(input mode_e op,
                                                    input logic signed [KEY_W-1:0] k,
                                                    input logic [PAY_IN_W-1:0] pay,
                                                    input logic [POS_W-1:0] pos);
    list_outcome_t r;
    bit            hit;
    int unsigned   at;
    int unsigned   probes;
    int unsigned   i;
    r = '0;
    case (op)
      MODE_FIND: begin
        scan_keys(k, hit, at, probes);
        r.probes = PROBE_W'(probes);
        if (hit) begin
          r.ok = 1'b1;
          r.at = POS_W'(at);
        end
      end
      MODE_ADD: begin
        // a full list refuses without searching
        if (shadow_count < CAPACITY) begin
          scan_keys(k, hit, at, probes);
          r.probes = PROBE_W'(probes);
          if (!hit) begin
            shadow_keys[shadow_count] = k;
            shadow_pays[shadow_count] = pay[PAYLOAD_BITS-1:0];
            r.at = POS_W'(shadow_count);
            r.ok = 1'b1;
            shadow_count++;
          end
        end
      end
      MODE_REMOVE: begin
        scan_keys(k, hit, at, probes);
        r.probes = PROBE_W'(probes);
        if (hit) begin
          for (i = at; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_pays[i] = shadow_pays[i + 1];
          end
          shadow_count--;
          r.ok = 1'b1;
          r.at = POS_W'(at);
        end
      end
      default: begin
        if (pos < shadow_count) begin
          r.ok = 1'b1;
          r.at = pos;
          r.rkey = shadow_keys[pos];
          r.rpay = shadow_pays[pos];
        end
      end
    endcase
    r.entries = ENTRY_W'(shadow_count);
    return r;
  endfunction

  function automatic logic [PAY_IN_W-1:0] rand_payload();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'($urandom());
  endfunction

  // mostly fresh keys, now and then the extremes
  function automatic logic signed [KEY_W-1:0] rand_key();
    case ($urandom_range(15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key(input int unsigned pct_listed);
    if (shadow_count != 0 && $urandom_range(99) < pct_listed)
      return shadow_keys[$urandom_range(shadow_count - 1)];
    return rand_key();
  endfunction

  task automatic note_mismatch(input string what, input logic [127:0] want,
                               input logic [127:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    list_outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        note_mismatch("result with nothing pending, tdata", '0, 128'(m_axis_tdata));
      end else begin
        want = due_results.pop_front();
        if (m_axis_tdata[0] !== want.ok)
          note_mismatch("ok", 128'(want.ok), 128'(m_axis_tdata[0]));
        if (m_axis_tdata[6:1] !== want.at)
          note_mismatch("found_position", 128'(want.at), 128'(m_axis_tdata[6:1]));
        if (m_axis_tdata[13:7] !== want.probes)
          note_mismatch("probe_count", 128'(want.probes), 128'(m_axis_tdata[13:7]));
        if (m_axis_tdata[45:14] !== want.rkey)
          note_mismatch("record_key", 128'(want.rkey), 128'(m_axis_tdata[45:14]));
        if (m_axis_tdata[109:46] !== want.rpay)
          note_mismatch("record_payload", 128'(want.rpay), 128'(m_axis_tdata[109:46]));
        if (m_axis_tdata[116:110] !== want.entries)
          note_mismatch("entries_now", 128'(want.entries), 128'(m_axis_tdata[116:110]));
      end
    end
  end

  // returns right after the transfer; valid stays up for the next call
  task automatic send_op(input mode_e op, input logic signed [KEY_W-1:0] k,
                         input logic [PAY_IN_W-1:0] pay, input logic [POS_W-1:0] pos);
    @(negedge clk_i);
    if (!steady) begin
      while ($urandom_range(99) < 27) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{S_FILL_W{1'b0}}, pos, pay, k};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    due_results.push_back(list_op_outcome(op, k, pay, pos));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_list();
    send_op(MODE_READ, rand_key(), rand_payload(), '0);
    send_op(MODE_READ, rand_key(), rand_payload(), '1);
    send_op(MODE_FIND, '0, rand_payload(), rand_pos());
    send_op(MODE_REMOVE, -32'sd1, rand_payload(), rand_pos());
  endtask

  task automatic test_basic_ops();
    send_op(MODE_ADD, 32'sh8000_0000, '1, '0);
    send_op(MODE_ADD, 32'sh7fff_ffff, '0, '1);
    send_op(MODE_ADD, '0, rand_payload(), rand_pos());
    send_op(MODE_ADD, -32'sd1, rand_payload(), rand_pos());
    // duplicate key is refused
    send_op(MODE_ADD, 32'sh7fff_ffff, rand_payload(), rand_pos());
    send_op(MODE_FIND, 32'sh8000_0000, rand_payload(), rand_pos());
    send_op(MODE_FIND, -32'sd1, rand_payload(), rand_pos());
    send_op(MODE_FIND, 32'sd12345, rand_payload(), rand_pos());
    send_op(MODE_READ, rand_key(), rand_payload(), 6'd0);
    send_op(MODE_READ, rand_key(), rand_payload(), 6'd1);
    send_op(MODE_READ, rand_key(), rand_payload(), 6'd2);
    send_op(MODE_READ, rand_key(), rand_payload(), 6'd3);
    send_op(MODE_READ, rand_key(), rand_payload(), 6'd4);
    // middle, last and first removals
    send_op(MODE_REMOVE, 32'sh7fff_ffff, rand_payload(), rand_pos());
    send_op(MODE_READ, rand_key(), rand_payload(), 6'd1);
    send_op(MODE_READ, rand_key(), rand_payload(), 6'd2);
    send_op(MODE_REMOVE, -32'sd1, rand_payload(), rand_pos());
    send_op(MODE_REMOVE, 32'sh8000_0000, rand_payload(), rand_pos());
    send_op(MODE_REMOVE, 32'sd7, rand_payload(), rand_pos());
    send_op(MODE_READ, rand_key(), rand_payload(), 6'd0);
    send_op(MODE_FIND, '0, rand_payload(), rand_pos());
    wait_drained();
  endtask

  task automatic test_full_list();
    while (shadow_count < CAPACITY)
      send_op(MODE_ADD, rand_key(), rand_payload(), rand_pos());
    send_op(MODE_ADD, rand_key(), rand_payload(), rand_pos());
    send_op(MODE_ADD, shadow_keys[0], rand_payload(), rand_pos());
    send_op(MODE_FIND, shadow_keys[CAPACITY - 1], rand_payload(), rand_pos());
    send_op(MODE_FIND, rand_key(), rand_payload(), rand_pos());
    send_op(MODE_READ, rand_key(), rand_payload(), 6'd63);
    // longest shift-down
    send_op(MODE_REMOVE, shadow_keys[0], rand_payload(), rand_pos());
    send_op(MODE_READ, rand_key(), rand_payload(), 6'd0);
    send_op(MODE_READ, rand_key(), rand_payload(), 6'd63);
    send_op(MODE_ADD, rand_key(), rand_payload(), rand_pos());
    send_op(MODE_REMOVE, shadow_keys[shadow_count - 1], rand_payload(), rand_pos());
    wait_drained();
  endtask

  task automatic send_random_op(input bit grow);
    mode_e                   op;
    logic signed [KEY_W-1:0] k;
    logic [POS_W-1:0]        pos;
    int unsigned             pick;
    pick = $urandom_range(99);
    if (pick < (grow ? 45 : 10))
      op = MODE_ADD;
    else if (pick < (grow ? 65 : 30))
      op = MODE_FIND;
    else if (pick < (grow ? 80 : 75))
      op = MODE_REMOVE;
    else
      op = MODE_READ;
    k = pick_key(op == MODE_ADD ? 30 : 70);
    pos = rand_pos();
    if (op == MODE_READ && shadow_count != 0 && $urandom_range(99) < 80)
      pos = POS_W'($urandom_range(shadow_count - 1));
    send_op(op, k, rand_payload(), pos);
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 7; phase++) begin
      steady = (phase == 3);
      repeat (100) send_random_op(phase % 2 == 0);
      if (phase == 3) begin
        wait_drained();
        steady = 1'b0;
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_empty_list();
    test_basic_ops();
    test_full_list();
    test_random_traffic();
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && due_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #1_500_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
